### hdl/cbhd_pkg.sv
// Shared types and constants for the compressed block header deframer.
`default_nettype none

package cbhd_pkg;

  // Checksum seed and flag-bit position of the final-block marker
  localparam logic [7:0] CHK_SEED   = 8'h5A;
  localparam int         FINAL_BIT  = 6;

  // Register index of the passthrough control bit
  localparam logic       REG_PASSTHROUGH = 1'b0;

  // Kind field codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Request class assigned by the front end
  typedef enum logic [1:0] {
    OP_PARSE_BYTE = 2'd0,
    OP_PASS_BYTE  = 2'd1,
    OP_PARSE_EOS  = 2'd2,
    OP_PASS_EOS   = 2'd3
  } op_t;

  // Header parse phase
  typedef enum logic [1:0] {
    PH_FLAGS   = 2'd0,
    PH_CHECK   = 2'd1,
    PH_SIZE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_NONE     = 3'd0,
    ROLE_FLAGS    = 3'd1,
    ROLE_CHECKSUM = 3'd2,
    ROLE_SIZE     = 3'd3,
    ROLE_PAYLOAD  = 3'd4,
    ROLE_PASS     = 3'd5
  } role_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_COUNT  = 3'd1,
    ST_CHECKSUM   = 3'd2,
    ST_AFTER_END  = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_NO_FINAL   = 3'd5,
    ST_REJECTED   = 3'd6
  } status_t;

  // Classified request queued between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       bad_count;   // size count code of 3
    logic [1:0] size_count;  // number of size bytes minus one
    logic       final_flag;  // flag 0x40 in this byte
  } cmd_t;

  // One result
  typedef struct packed {
    logic [7:0] out_byte;
    role_t      role;
    logic       block_end;
    logic       is_final_block;
    status_t    status;
    logic       stream_ok;
  } res_t;

endpackage

`default_nettype wire

### hdl/compressed_block_header_deframer_top.sv
// Top level of the compressed block header deframer: stream ports, register port, queue.
//
//  Channel   Dir  Handshake                  Contents
//  s_*       in   s_tvalid / s_tready        stream byte or end-of-stream request
//  m_*       out  m_tvalid / m_tready        tagged byte and status per request
//  APB       in   psel & penable & pwrite    passthrough register at address 0
//
// One request per cycle sustained while m_tready is held high; each result passes through
// a queue entry, then the back-end output register.
// Reset clears the parse state and the passthrough bit; no clearing pass.
// The two-entry queue decouples input from output: input is taken while a result
// waits, and stalls only once both queue entries are full.
`default_nettype none

module compressed_block_header_deframer_top
  import cbhd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] kind
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] is_final_block, [11:9] status,
                                 // [12] stream_ok, [15:13] zero
  output logic [2:0]       m_tuser,   // [2:0] role
  output logic             m_tlast,   // block_end
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic passthrough;
  cmd_t front_cmd;
  cmd_t head;
  logic fifo_full;
  logic fifo_empty;
  logic pop;
  logic push;
  res_t res;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      passthrough <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PASSTHROUGH)) begin
      passthrough <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_PASSTHROUGH) prdata = {31'd0, passthrough};
  end

  // Front end and queue
  assign s_tready = !fifo_full;
  assign push     = s_tvalid && s_tready;

  cbhd_front u_front (
    .kind        (s_tuser[0]),
    .data_byte   (s_tdata),
    .passthrough (passthrough),
    .cmd         (front_cmd)
  );

  cbhd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty)
  );

  // Back end
  cbhd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head),
    .cmd_valid (!fifo_empty),
    .cmd_pop   (pop),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {3'd0, res.stream_ok, res.status, res.is_final_block, res.out_byte};
  assign m_tuser = res.role;
  assign m_tlast = res.block_end;

endmodule

`default_nettype wire

### hdl/cbhd_front.sv
// Front end: classifies incoming requests by kind and mode, pre-decodes flag fields.
`default_nettype none

module cbhd_front
  import cbhd_pkg::*;
(
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       passthrough,
  output cmd_t            cmd
);

  always_comb begin
    cmd = '0;
    cmd.data       = data_byte;
    cmd.size_count = data_byte[4:3];
    cmd.bad_count  = (data_byte[4:3] == 2'd3);
    cmd.final_flag = data_byte[FINAL_BIT];
    unique case ({kind, passthrough})
      {KIND_DATA, 1'b0}: cmd.op = OP_PARSE_BYTE;
      {KIND_DATA, 1'b1}: cmd.op = OP_PASS_BYTE;
      {KIND_EOS,  1'b0}: cmd.op = OP_PARSE_EOS;
      default:           cmd.op = OP_PASS_EOS;
    endcase
  end

endmodule

`default_nettype wire

### hdl/cbhd_fifo.sv
// Two-entry request queue between the front end and the back end.
`default_nettype none

module cbhd_fifo
  import cbhd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

### hdl/cbhd_back.sv
// Back end: header parse state, checksum check, payload count and output register.
`default_nettype none

module cbhd_back
  import cbhd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      cmd,
  input  wire logic cmd_valid,
  output logic      cmd_pop,
  output res_t      res,
  output logic      res_valid,
  input  wire logic res_ready
);

  // Parse state
  phase_t      phase, phase_next;
  logic        final_hold, final_hold_next;
  logic [7:0]  saved_check, saved_check_next;
  logic [1:0]  size_left, size_left_next;
  logic [1:0]  size_shift, size_shift_next;
  logic [23:0] size_accum, size_accum_next;
  logic [7:0]  xor_accum, xor_accum_next;
  logic [23:0] payload_left, payload_left_next;
  logic        finished, finished_next;
  logic        aborted, aborted_next;
  res_t        res_next;

  logic [23:0] size_part;
  logic [23:0] size_new;
  logic [7:0]  xor_new;
  logic [1:0]  left_new;

  assign cmd_pop = cmd_valid && (!res_valid || res_ready);

  // Size byte placement, little-endian
  always_comb begin
    unique case (size_shift)
      2'd0:    size_part = {16'd0, cmd.data};
      2'd1:    size_part = {8'd0, cmd.data, 8'd0};
      2'd2:    size_part = {cmd.data, 16'd0};
      default: size_part = 24'd0;
    endcase
  end

  assign size_new = size_accum | size_part;
  assign xor_new  = xor_accum ^ cmd.data;
  assign left_new = size_left - 2'd1;

  // Next state and result
  always_comb begin
    phase_next        = phase;
    final_hold_next   = final_hold;
    saved_check_next  = saved_check;
    size_left_next    = size_left;
    size_shift_next   = size_shift;
    size_accum_next   = size_accum;
    xor_accum_next    = xor_accum;
    payload_left_next = payload_left;
    finished_next     = finished;
    aborted_next      = aborted;
    res_next          = '0;
    res_next.role     = ROLE_NONE;
    res_next.status   = ST_OK;

    if (aborted) begin
      res_next.status = ST_REJECTED;
    end else begin
      unique case (cmd.op)
        OP_PASS_EOS: begin
          finished_next      = 1'b1;
          res_next.stream_ok = 1'b1;
        end
        OP_PARSE_EOS: begin
          if (phase != PH_FLAGS) begin
            aborted_next    = 1'b1;
            res_next.status = ST_TRUNCATED;
          end else if (!finished) begin
            aborted_next    = 1'b1;
            res_next.status = ST_NO_FINAL;
          end else begin
            res_next.stream_ok = 1'b1;
          end
        end
        OP_PASS_BYTE: begin
          if (finished) begin
            aborted_next    = 1'b1;
            res_next.status = ST_AFTER_END;
          end else begin
            res_next.out_byte = cmd.data;
            res_next.role     = ROLE_PASS;
          end
        end
        default: begin
          if (finished) begin
            aborted_next    = 1'b1;
            res_next.status = ST_AFTER_END;
          end else begin
            unique case (phase)
              PH_FLAGS: begin
                if (cmd.bad_count) begin
                  aborted_next    = 1'b1;
                  res_next.status = ST_BAD_COUNT;
                end else begin
                  final_hold_next         = cmd.final_flag;
                  xor_accum_next          = CHK_SEED ^ cmd.data;
                  size_left_next          = cmd.size_count + 2'd1;
                  phase_next              = PH_CHECK;
                  res_next.out_byte       = cmd.data;
                  res_next.role           = ROLE_FLAGS;
                  res_next.is_final_block = cmd.final_flag;
                end
              end
              PH_CHECK: begin
                saved_check_next        = cmd.data;
                size_shift_next         = 2'd0;
                size_accum_next         = 24'd0;
                phase_next              = PH_SIZE;
                res_next.out_byte       = cmd.data;
                res_next.role           = ROLE_CHECKSUM;
                res_next.is_final_block = final_hold;
              end
              PH_SIZE: begin
                size_accum_next = size_new;
                xor_accum_next  = xor_new;
                size_shift_next = size_shift + 2'd1;
                size_left_next  = left_new;
                if (left_new != 2'd0) begin
                  res_next.out_byte       = cmd.data;
                  res_next.role           = ROLE_SIZE;
                  res_next.is_final_block = final_hold;
                end else if (xor_new != saved_check) begin
                  aborted_next    = 1'b1;
                  res_next.status = ST_CHECKSUM;
                end else begin
                  res_next.out_byte       = cmd.data;
                  res_next.role           = ROLE_SIZE;
                  res_next.is_final_block = final_hold;
                  if (size_new == 24'd0) begin
                    // empty block ends on its last size byte
                    res_next.block_end = 1'b1;
                    phase_next         = PH_FLAGS;
                    if (final_hold) finished_next = 1'b1;
                  end else begin
                    payload_left_next = size_new;
                    phase_next        = PH_PAYLOAD;
                  end
                end
              end
              default: begin
                payload_left_next       = payload_left - 24'd1;
                res_next.out_byte       = cmd.data;
                res_next.role           = ROLE_PAYLOAD;
                res_next.is_final_block = final_hold;
                if (payload_left == 24'd1) begin
                  res_next.block_end = 1'b1;
                  phase_next         = PH_FLAGS;
                  if (final_hold) finished_next = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // State registers, updated once per popped request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAGS;
      final_hold   <= 1'b0;
      saved_check  <= 8'd0;
      size_left    <= 2'd0;
      size_shift   <= 2'd0;
      size_accum   <= 24'd0;
      xor_accum    <= 8'd0;
      payload_left <= 24'd0;
      finished     <= 1'b0;
      aborted      <= 1'b0;
    end else if (cmd_pop) begin
      phase        <= phase_next;
      final_hold   <= final_hold_next;
      saved_check  <= saved_check_next;
      size_left    <= size_left_next;
      size_shift   <= size_shift_next;
      size_accum   <= size_accum_next;
      xor_accum    <= xor_accum_next;
      payload_left <= payload_left_next;
      finished     <= finished_next;
      aborted      <= aborted_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) res <= res_next;
  end

endmodule

`default_nettype wire
